### sv/tw_pkg.sv
package tw_pkg;

    localparam int WHEEL_SLOTS  = 1024;
    localparam int SLOT_W       = $clog2(WHEEL_SLOTS);
    localparam int POOL_ENTRIES = 32;
    localparam int POOL_W       = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int LINK_W       = 6;
    localparam logic [LINK_W-1:0] NIL_LINK = 6'd63;
    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic {
        FUNC_SCHEDULE = 1'b0,
        FUNC_ADVANCE  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        KIND_FIRED     = 2'd0,
        KIND_SCHEDULED = 2'd1,
        KIND_DROPPED   = 2'd2,
        KIND_DONE      = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCH_RD,
        ST_SCH_WAIT,
        ST_SCH_HEAD,
        ST_SCH_WALK,
        ST_ADV_RD,
        ST_ADV_WAIT,
        ST_ADV_HEAD,
        ST_ADV_DONE
    } state_t;

    typedef struct packed {
        func_t             func;
        logic [31:0]       delay;
        logic signed [7:0] prio;
        logic [7:0]        handler;
        logic [31:0]       message;
        logic [31:0]       target;
        logic [15:0]       step;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } eng_status_t;

    // (d1,p1) at or before (d2,p2): due compared unsigned, then signed priority
    function automatic logic at_or_before(input logic [31:0] d1, input logic signed [7:0] p1,
                                          input logic [31:0] d2, input logic signed [7:0] p2);
        return (d1 < d2) || ((d1 == d2) && (p1 <= p2));
    endfunction

    function automatic logic [POOL_W-1:0] lowest_free(input logic [POOL_ENTRIES-1:0] m);
        logic [POOL_W-1:0] r;
        r = '0;
        for (int k = POOL_ENTRIES - 1; k >= 0; k--) begin
            if (m[k])
            begin
                r = POOL_W'(k);
            end
        end
        return r;
    endfunction

endpackage

### sv/tw_ram.sv
module tw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### sv/tw_queue.sv
module tw_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  tw_pkg::cmd_t push_data,
    output logic         full,
    input  logic         pop,
    output tw_pkg::cmd_t pop_data,
    output logic         empty
);
    import tw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    cmd_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;

    assign full     = (cnt_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end
endmodule

### sv/tw_engine.sv
module tw_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  tw_pkg::cmd_t        q_data,
    output logic                q_pop,
    output tw_pkg::eng_status_t status,
    output logic                out_valid,
    input  logic                out_ready,
    output tw_pkg::kind_t       out_kind,
    output logic [7:0]          out_handler,
    output logic [31:0]         out_message,
    output logic [31:0]         out_target,
    output logic [31:0]         out_due,
    output logic                out_last
);
    import tw_pkg::*;

    state_t                   state_reg, state_next;
    cmd_t                     cmd_reg, cmd_next;
    logic [31:0]              now_reg, now_next;
    logic [31:0]              due_reg, due_next;   // new due time, or cut-off on advance
    logic [POOL_ENTRIES-1:0]  free_reg, free_next;
    logic [LINK_W-1:0]        h_reg, h_next;
    logic [LINK_W-1:0]        c_reg, c_next;
    logic [LINK_W-1:0]        n_reg, n_next;
    logic [15:0]              i_reg, i_next;
    logic [SLOT_W-1:0]        clr_reg, clr_next;

    // task pool, one read port
    logic [31:0]              pdue_reg  [POOL_ENTRIES];
    logic signed [7:0]        pprio_reg [POOL_ENTRIES];
    logic [7:0]               phand_reg [POOL_ENTRIES];
    logic [31:0]              pmsg_reg  [POOL_ENTRIES];
    logic [31:0]              ptgt_reg  [POOL_ENTRIES];
    logic [LINK_W-1:0]        plink_reg [POOL_ENTRIES];

    logic [POOL_W-1:0]        rd_idx;
    logic [31:0]              rd_due;
    logic signed [7:0]        rd_prio;
    logic [LINK_W-1:0]        rd_link;
    logic [POOL_W-1:0]        alloc;

    logic                     new_we;
    logic [LINK_W-1:0]        new_link;
    logic                     link_we;
    logic [POOL_W-1:0]        link_idx;

    logic                     ram_we, ram_re;
    logic [SLOT_W-1:0]        ram_waddr, ram_raddr;
    logic [LINK_W-1:0]        ram_wdata, ram_rdata;

    logic                     out_valid_reg;
    kind_t                    kind_reg;
    logic [7:0]               hand_reg;
    logic [31:0]              msg_reg, tgt_reg, odue_reg;
    logic                     last_reg;

    logic                     out_free;
    logic                     emit;
    kind_t                    e_kind;
    logic [7:0]               e_hand;
    logic [31:0]              e_msg, e_tgt, e_due;
    logic                     e_last;
    logic [SLOT_W-1:0]        adv_slot;

    tw_ram #(.WIDTH(LINK_W), .DEPTH(WHEEL_SLOTS)) u_heads (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_due   = pdue_reg[rd_idx];
    assign rd_prio  = pprio_reg[rd_idx];
    assign rd_link  = plink_reg[rd_idx];
    assign alloc    = lowest_free(free_reg);
    assign out_free = !out_valid_reg || out_ready;
    assign adv_slot = now_reg[SLOT_W-1:0] + i_reg[SLOT_W-1:0];
    assign status.clearing = (state_reg == ST_CLEAR);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        now_next   = now_reg;
        due_next   = due_reg;
        free_next  = free_reg;
        h_next     = h_reg;
        c_next     = c_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        clr_next   = clr_reg;
        q_pop      = 1'b0;
        rd_idx     = h_reg[POOL_W-1:0];
        new_we     = 1'b0;
        new_link   = NIL_LINK;
        link_we    = 1'b0;
        link_idx   = c_reg[POOL_W-1:0];
        ram_we     = 1'b0;
        ram_waddr  = due_reg[SLOT_W-1:0];
        ram_wdata  = NIL_LINK;
        ram_re     = 1'b0;
        ram_raddr  = due_reg[SLOT_W-1:0];
        emit       = 1'b0;
        e_kind     = KIND_DONE;
        e_hand     = '0;
        e_msg      = '0;
        e_tgt      = '0;
        e_due      = due_reg;
        e_last     = 1'b1;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = NIL_LINK;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == SLOT_W'(WHEEL_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                    i_next   = '0;
                    if (q_data.func == FUNC_SCHEDULE)
                    begin
                        due_next   = now_reg + q_data.delay;
                        state_next = ST_SCH_RD;
                    end
                    else
                    begin
                        due_next   = now_reg + 32'(q_data.step);
                        state_next = ST_ADV_RD;
                    end
                end
            end
            ST_SCH_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_SCH_WAIT;
            end
            ST_SCH_WAIT:
            begin
                h_next     = ram_rdata;
                state_next = ST_SCH_HEAD;
            end
            ST_SCH_HEAD:
            begin
                rd_idx = h_reg[POOL_W-1:0];
                if (free_reg == '0)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        e_kind     = KIND_DROPPED;
                        state_next = ST_IDLE;
                    end
                end
                else if (h_reg >= LINK_W'(POOL_ENTRIES)
                         || at_or_before(due_reg, cmd_reg.prio, rd_due, rd_prio))
                begin
                    // new task becomes the slot head
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        e_kind     = KIND_SCHEDULED;
                        new_we     = 1'b1;
                        new_link   = h_reg;
                        free_next  = free_reg & ~(POOL_ENTRIES'(1) << alloc);
                        ram_we     = 1'b1;
                        ram_wdata  = LINK_W'(alloc);
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    c_next     = h_reg;
                    n_next     = rd_link;
                    state_next = ST_SCH_WALK;
                end
            end
            ST_SCH_WALK:
            begin
                rd_idx = n_reg[POOL_W-1:0];
                if (n_reg >= LINK_W'(POOL_ENTRIES)
                    || !at_or_before(rd_due, rd_prio, due_reg, cmd_reg.prio))
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        e_kind     = KIND_SCHEDULED;
                        new_we     = 1'b1;
                        new_link   = n_reg;
                        link_we    = 1'b1;
                        link_idx   = c_reg[POOL_W-1:0];
                        free_next  = free_reg & ~(POOL_ENTRIES'(1) << alloc);
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    c_next = n_reg;
                    n_next = rd_link;
                end
            end
            ST_ADV_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = adv_slot;
                state_next = ST_ADV_WAIT;
            end
            ST_ADV_WAIT:
            begin
                h_next     = ram_rdata;
                state_next = ST_ADV_HEAD;
            end
            ST_ADV_HEAD:
            begin
                rd_idx = h_reg[POOL_W-1:0];
                if (h_reg < LINK_W'(POOL_ENTRIES)
                    && at_or_before(rd_due, rd_prio, due_reg, cmd_reg.prio))
                begin
                    if (out_free)
                    begin
                        emit      = 1'b1;
                        e_kind    = KIND_FIRED;
                        e_hand    = phand_reg[rd_idx];
                        e_msg     = pmsg_reg[rd_idx];
                        e_tgt     = ptgt_reg[rd_idx];
                        e_due     = rd_due;
                        e_last    = 1'b0;
                        free_next = free_reg | (POOL_ENTRIES'(1) << rd_idx);
                        ram_we    = 1'b1;
                        ram_waddr = adv_slot;
                        ram_wdata = rd_link;
                        h_next    = rd_link;
                    end
                end
                else if (i_reg == cmd_reg.step)
                begin
                    state_next = ST_ADV_DONE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_ADV_RD;
                end
            end
            ST_ADV_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_DONE;
                    now_next   = due_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            now_reg       <= '0;
            free_reg      <= '1;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            now_reg   <= now_next;
            free_reg  <= free_next;
            clr_reg   <= clr_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        due_reg <= due_next;
        h_reg   <= h_next;
        c_reg   <= c_next;
        n_reg   <= n_next;
        i_reg   <= i_next;
        if (emit)
        begin
            kind_reg <= e_kind;
            hand_reg <= e_hand;
            msg_reg  <= e_msg;
            tgt_reg  <= e_tgt;
            odue_reg <= e_due;
            last_reg <= e_last;
        end
        if (new_we)
        begin
            pdue_reg[alloc]  <= due_reg;
            pprio_reg[alloc] <= cmd_reg.prio;
            phand_reg[alloc] <= cmd_reg.handler;
            pmsg_reg[alloc]  <= cmd_reg.message;
            ptgt_reg[alloc]  <= cmd_reg.target;
            plink_reg[alloc] <= new_link;
        end
        if (link_we)
        begin
            plink_reg[link_idx] <= LINK_W'(alloc);
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = kind_reg;
    assign out_handler = hand_reg;
    assign out_message = msg_reg;
    assign out_target  = tgt_reg;
    assign out_due     = odue_reg;
    assign out_last    = last_reg;
endmodule

### sv/timing_wheel_event_scheduler.sv
// Hashed timing wheel scheduler. A schedule transaction (tuser = 0) files a task
// at due = now + delay into wheel slot due mod 1024, in a list sorted by due time
// then signed priority, and answers with one "scheduled" result, or one "dropped"
// result when all 32 pool entries are taken. An advance transaction (tuser = 1)
// visits slots now..now+step, pops every head task at or before
// (now+step, priority_req) as one "fired" result each, then adds step to now
// and ends with a "done" result carrying the new time; tlast marks the final
// result of each transaction. Commands pass through a two-entry queue to a
// sequencer that owns the 1024-entry slot-head RAM and the task pool. A
// schedule reads the slot head, then walks the list entry by entry to the
// insertion point; an advance reads each of the step+1 visited slots and
// pops its due head tasks one by one; a result held by a stalled m_axis_tready
// holds the sequencer too. After reset the head RAM is cleared one slot per
// cycle, and s_axis_tready stays low until that is done.
module timing_wheel_event_scheduler (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // delay[31:0], priority_req[39:32], handler[47:40], message[79:48],
    // target[111:80], step[127:112]
    input  logic [127:0] s_axis_tdata,
    // func
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // handler_res[7:0], message_res[39:8], target_res[71:40], due_time[103:72]
    output logic [103:0] m_axis_tdata,
    // kind[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import tw_pkg::*;

    cmd_t        in_cmd, q_data;
    logic        q_full, q_empty, q_pop, push;
    eng_status_t status;
    kind_t       out_kind;
    logic [7:0]  out_handler;
    logic [31:0] out_message, out_target, out_due;

    // front: classify and pack the incoming transaction
    assign in_cmd.func    = func_t'(s_axis_tuser);
    assign in_cmd.delay   = s_axis_tdata[31:0];
    assign in_cmd.prio    = s_axis_tdata[39:32];
    assign in_cmd.handler = s_axis_tdata[47:40];
    assign in_cmd.message = s_axis_tdata[79:48];
    assign in_cmd.target  = s_axis_tdata[111:80];
    assign in_cmd.step    = s_axis_tdata[127:112];

    assign s_axis_tready = !q_full && !status.clearing;
    assign push          = s_axis_tvalid && s_axis_tready;

    tw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (in_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    // back: list walks, slot visits, result register
    tw_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .status      (status),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_kind    (out_kind),
        .out_handler (out_handler),
        .out_message (out_message),
        .out_target  (out_target),
        .out_due     (out_due),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = {out_due, out_target, out_message, out_handler};
endmodule

### sv/tw_checker.sv
module tw_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser,
    input logic         m_axis_tlast
);
    import tw_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_FIRED |-> !m_axis_tlast)
        else $error("fired task marked last");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_SCHEDULED || m_axis_tuser == KIND_DROPPED
                          || m_axis_tuser == KIND_DONE) |-> m_axis_tlast)
        else $error("closing result without tlast");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_FIRED |-> m_axis_tdata[71:0] == '0)
        else $error("payload not cleared on non-fired result");
endmodule

bind timing_wheel_event_scheduler tw_checker u_tw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
